// ===== design/lpg_pkg.sv =====
// Shared types and constants for the line pixel generator.
package lpg_pkg;

   localparam int X_WIDTH     = 10;
   localparam int Y_WIDTH     = 9;
   localparam int COLOR_WIDTH = 16;
   localparam int ERR_WIDTH   = 12;

   // Transaction kinds on the request channel.
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [X_WIDTH-1:0]     start_x;
      logic [Y_WIDTH-1:0]     start_y;
      logic [X_WIDTH-1:0]     end_x;
      logic [Y_WIDTH-1:0]     end_y;
      logic [COLOR_WIDTH-1:0] color_in;
   } lpg_req_type;

   typedef struct packed {
      logic [X_WIDTH-1:0]     pixel_x;
      logic [Y_WIDTH-1:0]     pixel_y;
      logic [COLOR_WIDTH-1:0] pixel_color;
      logic                   last_pixel;
   } lpg_rsp_type;

   // Walk state of the active line.
   typedef struct packed {
      logic [X_WIDTH-1:0]         pos_x;
      logic [Y_WIDTH-1:0]         pos_y;
      logic [X_WIDTH-1:0]         goal_x;
      logic [Y_WIDTH-1:0]         goal_y;
      logic [X_WIDTH-1:0]         span_x;
      logic [Y_WIDTH-1:0]         span_y;
      logic signed [ERR_WIDTH-1:0] error_term;
      logic                       dir_x;
      logic                       dir_y;
      logic [COLOR_WIDTH-1:0]     pen_color;
      logic                       busy;
   } lpg_state_type;

endpackage

// ===== design/lpg_if.sv =====
// Valid/ready channel interfaces for requests and pixel responses.
interface lpg_req_if;
   import lpg_pkg::*;

   logic        valid;
   logic        ready;
   lpg_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lpg_rsp_if;
   import lpg_pkg::*;

   logic        valid;
   logic        ready;
   lpg_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/lpg_step.sv =====
// Single-step line walker: next state and emitted pixel for one transaction.
module lpg_step #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  lpg_pkg::lpg_req_type   item,
   input  lpg_pkg::lpg_state_type state_cur,
   output lpg_pkg::lpg_state_type state_next,
   output lpg_pkg::lpg_rsp_type   pixel,
   output logic                   emit
);
   import lpg_pkg::*;

   localparam int X_MAX = (1 << X_WIDTH) - 1;
   localparam int Y_MAX = (1 << Y_WIDTH) - 1;
   localparam int X_LIM_INT = (SCREEN_WIDTH - 1 > X_MAX) ? X_MAX : SCREEN_WIDTH - 1;
   localparam int Y_LIM_INT = (SCREEN_HEIGHT - 1 > Y_MAX) ? Y_MAX : SCREEN_HEIGHT - 1;
   localparam logic [X_WIDTH-1:0] X_LIMIT = X_LIM_INT[X_WIDTH-1:0];
   localparam logic [Y_WIDTH-1:0] Y_LIMIT = Y_LIM_INT[Y_WIDTH-1:0];

   logic [X_WIDTH-1:0] sx, gx, new_span_x;
   logic [Y_WIDTH-1:0] sy, gy, new_span_y;
   logic               new_dir_x, new_dir_y, new_x_major;
   logic [X_WIDTH-1:0] new_major, new_minor;
   logic               x_major, err_pos, step_x, step_y;
   logic [X_WIDTH-1:0] major, minor, next_x;
   logic [Y_WIDTH-1:0] next_y;
   logic signed [ERR_WIDTH-1:0] err_delta;
   logic               start_last, walk_last;

   // Endpoint saturation to the visible frame.
   assign sx = (item.start_x > X_LIMIT) ? X_LIMIT : item.start_x;
   assign sy = (item.start_y > Y_LIMIT) ? Y_LIMIT : item.start_y;
   assign gx = (item.end_x > X_LIMIT) ? X_LIMIT : item.end_x;
   assign gy = (item.end_y > Y_LIMIT) ? Y_LIMIT : item.end_y;

   // Line set-up: directions, absolute spans and the initial decision value.
   assign new_dir_x   = gx < sx;
   assign new_dir_y   = gy < sy;
   assign new_span_x  = new_dir_x ? (sx - gx) : (gx - sx);
   assign new_span_y  = new_dir_y ? (sy - gy) : (gy - sy);
   assign new_x_major = new_span_x >= {1'b0, new_span_y};
   assign new_major   = new_x_major ? new_span_x : {1'b0, new_span_y};
   assign new_minor   = new_x_major ? {1'b0, new_span_y} : new_span_x;
   assign start_last  = (sx == gx) && (sy == gy);

   // One step of the walk along the major axis.
   assign x_major = state_cur.span_x >= {1'b0, state_cur.span_y};
   assign major   = x_major ? state_cur.span_x : {1'b0, state_cur.span_y};
   assign minor   = x_major ? {1'b0, state_cur.span_y} : state_cur.span_x;
   assign err_pos = !state_cur.error_term[ERR_WIDTH-1];
   assign step_x  = x_major || err_pos;
   assign step_y  = !x_major || err_pos;
   assign next_x  = !step_x ? state_cur.pos_x :
                    (state_cur.dir_x ? state_cur.pos_x - 1'b1 : state_cur.pos_x + 1'b1);
   assign next_y  = !step_y ? state_cur.pos_y :
                    (state_cur.dir_y ? state_cur.pos_y - 1'b1 : state_cur.pos_y + 1'b1);
   assign err_delta = err_pos ? ({1'b0, minor, 1'b0} - {1'b0, major, 1'b0})
                              : {1'b0, minor, 1'b0};
   assign walk_last = (next_x == state_cur.goal_x) && (next_y == state_cur.goal_y);

   // Select between starting a line, advancing it, or ignoring an idle advance.
   always_comb begin
      state_next = state_cur;
      emit       = 1'b0;
      if (item.kind == KIND_START) begin
         state_next.pos_x      = sx;
         state_next.pos_y      = sy;
         state_next.goal_x     = gx;
         state_next.goal_y     = gy;
         state_next.span_x     = new_span_x;
         state_next.span_y     = new_span_y;
         state_next.dir_x      = new_dir_x;
         state_next.dir_y      = new_dir_y;
         state_next.pen_color  = item.color_in;
         state_next.error_term = {1'b0, new_minor, 1'b0} - {2'b00, new_major};
         state_next.busy       = !start_last;
         emit                  = 1'b1;
      end else if (state_cur.busy) begin
         state_next.pos_x      = next_x;
         state_next.pos_y      = next_y;
         state_next.error_term = state_cur.error_term + err_delta;
         state_next.busy       = !walk_last;
         emit                  = 1'b1;
      end
   end

   // The pixel is the position after the update.
   assign pixel.pixel_x     = state_next.pos_x;
   assign pixel.pixel_y     = state_next.pos_y;
   assign pixel.pixel_color = state_next.pen_color;
   assign pixel.last_pixel  = !state_next.busy;

endmodule

// ===== design/line_pixel_generator.sv =====
// Top level of the line pixel generator: registers and channel handshakes.
//
// Requests arrive on req_port. A start transaction loads two endpoints and a
// colour and returns the first pixel; each advance transaction returns the
// next pixel of the line, and the endpoint pixel has last_pixel set. An
// advance with no line active returns nothing. Endpoints beyond the frame
// are saturated to its last column and row.
// Pixels leave on rsp_port as valid/ready transactions.
// A request is held in an input register, and one pass of the step logic
// updates the walk state and writes the response register.
// Throughput is one transaction per cycle while the receiver is ready; one
// pass of the step logic, either the line set-up or a single add-compare on
// the error term, is the only work between the two registers.
// When the receiver stalls, the response register holds its pixel and the
// input register holds one more request; req_port.ready then falls.
// Reset is synchronous: it empties both registers and clears the walk state,
// so no line is active afterwards.
module line_pixel_generator #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input logic       clock,
   input logic       reset,
   lpg_req_if.sink   req_port,
   lpg_rsp_if.source rsp_port
);
   import lpg_pkg::*;

   logic          req_valid_ff, req_valid_in;
   lpg_req_type   req_ff, req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lpg_rsp_type   rsp_ff, rsp_in;
   lpg_state_type state_ff, state_in;
   lpg_state_type step_state;
   lpg_rsp_type   step_pixel;
   logic          step_emit;
   logic          move;
   logic          req_take;

   // The held request moves on when the response register is free or draining.
   assign move     = req_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_take = req_port.valid && req_port.ready;
   assign req_port.ready = !req_valid_ff || move;

   lpg_step #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_step (
      .item       (req_ff),
      .state_cur  (state_ff),
      .state_next (step_state),
      .pixel      (step_pixel),
      .emit       (step_emit)
   );

   // Next values of the input register, walk state and response register.
   always_comb begin
      req_in       = req_take ? req_port.payload : req_ff;
      req_valid_in = req_take ? 1'b1 : (move ? 1'b0 : req_valid_ff);
      state_in     = move ? step_state : state_ff;
      rsp_in       = (move && step_emit) ? step_pixel : rsp_ff;
      if (move) begin
         rsp_valid_in = step_emit;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and walk state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_ff;

endmodule

// ===== dv/tb_line_pixel_generator.sv =====
// Self-checking testbench for the line pixel generator: a pixel predictor, random traffic and checks.
`timescale 1ns / 1ps

module tb_line_pixel_generator;
   import lpg_pkg::*;

   localparam int FRAME_COLUMNS = 640;
   localparam int FRAME_ROWS    = 480;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int TARGET_ITEMS  = 1300;
   localparam int REPORT_LIMIT  = 40;

   // Walks the same line as the block and keeps the pixels still owed by it.
   class pixel_scoreboard;
      lpg_rsp_type            owed_pixels[$];
      int                     errors;
      int                     pixels_checked;
      int                     lines_started;
      int                     idle_advances;
      bit [X_WIDTH-1:0]       cur_x;
      bit [X_WIDTH-1:0]       aim_x;
      bit [X_WIDTH-1:0]       run_x;
      bit [Y_WIDTH-1:0]       cur_y;
      bit [Y_WIDTH-1:0]       aim_y;
      bit [Y_WIDTH-1:0]       run_y;
      bit signed [ERR_WIDTH-1:0] decision;
      bit                     back_x;
      bit                     back_y;
      bit [COLOR_WIDTH-1:0]   ink;
      bit                     drawing;

      function new();
         errors = 0;
         pixels_checked = 0;
         lines_started = 0;
         idle_advances = 0;
         cur_x = '0; aim_x = '0; run_x = '0;
         cur_y = '0; aim_y = '0; run_y = '0;
         decision = '0;
         back_x = 1'b0; back_y = 1'b0;
         ink = '0;
         drawing = 1'b0;
      endfunction

      // Coordinates beyond the frame are held at its last column or row.
      static function bit [X_WIDTH-1:0] saturate(bit [X_WIDTH-1:0] value, int limit);
         if (int'(value) > limit - 1)
            return X_WIDTH'(limit - 1);
         return value;
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Works out the pixel, if any, that an accepted request transaction causes.
      function void note_request(lpg_req_type req);
         lpg_rsp_type pixel;
         bit          x_major;
         int          major;
         int          minor;
         bit          at_goal;
         if (req.kind == KIND_START) begin
            cur_x = saturate(req.start_x, FRAME_COLUMNS);
            cur_y = Y_WIDTH'(saturate({1'b0, req.start_y}, FRAME_ROWS));
            aim_x = saturate(req.end_x, FRAME_COLUMNS);
            aim_y = Y_WIDTH'(saturate({1'b0, req.end_y}, FRAME_ROWS));
            ink = req.color_in;
            back_x = aim_x < cur_x;
            back_y = aim_y < cur_y;
            run_x = back_x ? cur_x - aim_x : aim_x - cur_x;
            run_y = back_y ? cur_y - aim_y : aim_y - cur_y;
            x_major = run_x >= run_y;
            major = x_major ? int'(run_x) : int'(run_y);
            minor = x_major ? int'(run_y) : int'(run_x);
            decision = ERR_WIDTH'(2 * minor - major);
            lines_started++;
         end else begin
            if (!drawing) begin
               idle_advances++;
               return;
            end
            x_major = run_x >= run_y;
            major = x_major ? int'(run_x) : int'(run_y);
            minor = x_major ? int'(run_y) : int'(run_x);
            // One step on the major axis, and on the minor axis too when the error allows.
            if (x_major)
               cur_x = back_x ? cur_x - 1'b1 : cur_x + 1'b1;
            else
               cur_y = back_y ? cur_y - 1'b1 : cur_y + 1'b1;
            if (decision >= 0) begin
               if (x_major)
                  cur_y = back_y ? cur_y - 1'b1 : cur_y + 1'b1;
               else
                  cur_x = back_x ? cur_x - 1'b1 : cur_x + 1'b1;
               decision = ERR_WIDTH'(int'(decision) + 2 * minor - 2 * major);
            end else begin
               decision = ERR_WIDTH'(int'(decision) + 2 * minor);
            end
         end
         at_goal = (cur_x == aim_x) && (cur_y == aim_y);
         drawing = !at_goal;
         pixel.pixel_x = cur_x;
         pixel.pixel_y = cur_y;
         pixel.pixel_color = ink;
         pixel.last_pixel = at_goal;
         owed_pixels.push_back(pixel);
      endfunction

      // Compares a pixel from the block with the oldest one owed.
      task check_pixel(lpg_rsp_type got);
         lpg_rsp_type want;
         if (owed_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.pixel_x, got.pixel_y));
            return;
         end
         want = owed_pixels.pop_front();
         pixels_checked++;
         if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, wanted %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, wanted %0d", got.pixel_y, want.pixel_y));
         if (got.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color %h, wanted %h",
                                      got.pixel_color, want.pixel_color));
         if (got.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel %b, wanted %b at (%0d,%0d)",
                                      got.last_pixel, want.last_pixel,
                                      want.pixel_x, want.pixel_y));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   steady_sender;
   bit   steady_receiver;
   int   useful_items;

   lpg_req_if req_bus ();
   lpg_rsp_if rsp_bus ();

   pixel_scoreboard board = new();

   line_pixel_generator #(
      .SCREEN_WIDTH  (FRAME_COLUMNS),
      .SCREEN_HEIGHT (FRAME_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are watched at every edge; results are checked before new requests are noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_pixel(rsp_bus.payload);
         if (req_bus.valid && req_bus.ready)
            board.note_request(req_bus.payload);
      end
   end

   // Unless steady, the receiver holds ready low for a random number of cycles, possibly none, after each transaction.
   int hold_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         hold_cycles = steady_receiver ? 0 : $urandom_range(0, 6);
         if (hold_cycles > 0)
            rsp_bus.ready <= 1'b0;
      end else if (!rsp_bus.ready) begin
         if (hold_cycles > 0)
            hold_cycles--;
         if (hold_cycles == 0)
            rsp_bus.ready <= 1'b1;
      end
   end

   // The run ends with a failure if neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_line_pixel_generator: done, errors");
      $finish;
   end

   function automatic int bound(int value, int low, int high);
      if (value < low)
         return low;
      if (value > high)
         return high;
      return value;
   endfunction

   // Sends one request transaction after a random gap and waits for it to be taken.
   task automatic send_request(lpg_req_type item);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.payload <= item;
      req_bus.valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   task automatic start_line(int sx, int sy, int ex, int ey, int color);
      lpg_req_type item;
      item.kind = KIND_START;
      item.start_x = X_WIDTH'(sx);
      item.start_y = Y_WIDTH'(sy);
      item.end_x = X_WIDTH'(ex);
      item.end_y = Y_WIDTH'(ey);
      item.color_in = COLOR_WIDTH'(color);
      send_request(item);
   endtask

   // Advance transactions carry random junk in the fields they do not use.
   task automatic advance_line(int count);
      lpg_req_type item;
      repeat (count) begin
         item.kind = KIND_ADVANCE;
         item.start_x = X_WIDTH'($urandom_range(0, 1023));
         item.start_y = Y_WIDTH'($urandom_range(0, 511));
         item.end_x = X_WIDTH'($urandom_range(0, 1023));
         item.end_y = Y_WIDTH'($urandom_range(0, 511));
         item.color_in = COLOR_WIDTH'($urandom_range(0, 65535));
         send_request(item);
      end
   endtask

   // Stops sending and waits until every owed pixel has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.owed_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random line: a start, then advances that run to the end, stop short or overshoot.
   task automatic random_line();
      int sx, sy, ex, ey, reach, steps, walk, pick;
      pick = $urandom_range(0, 99);
      sx = $urandom_range(0, FRAME_COLUMNS - 1);
      sy = $urandom_range(0, FRAME_ROWS - 1);
      if (pick < 65) begin
         ex = bound(sx + $urandom_range(0, 30) - 15, 0, FRAME_COLUMNS - 1);
         ey = bound(sy + $urandom_range(0, 30) - 15, 0, FRAME_ROWS - 1);
      end else if (pick < 80) begin
         // Axis-aligned, diagonal and single-point lines.
         reach = $urandom_range(0, 20);
         ex = bound(sx + reach * (int'($urandom_range(0, 2)) - 1), 0, FRAME_COLUMNS - 1);
         ey = bound(sy + reach * (int'($urandom_range(0, 2)) - 1), 0, FRAME_ROWS - 1);
      end else if (pick < 90) begin
         ex = bound(sx + $urandom_range(0, 200) - 100, 0, FRAME_COLUMNS - 1);
         ey = bound(sy + $urandom_range(0, 200) - 100, 0, FRAME_ROWS - 1);
      end else if (pick < 96) begin
         // Endpoints around the far corner, many of them beyond the frame.
         sx = $urandom_range(600, 1023);
         ex = $urandom_range(600, 1023);
         sy = $urandom_range(450, 511);
         ey = $urandom_range(450, 511);
      end else begin
         sx = $urandom_range(0, 1023);
         ex = $urandom_range(0, 1023);
         sy = $urandom_range(0, 511);
         ey = $urandom_range(0, 511);
      end
      start_line(sx, sy, ex, ey, $urandom_range(0, 65535));
      steps = bound(ex, 0, FRAME_COLUMNS - 1) - bound(sx, 0, FRAME_COLUMNS - 1);
      reach = bound(ey, 0, FRAME_ROWS - 1) - bound(sy, 0, FRAME_ROWS - 1);
      steps = steps < 0 ? -steps : steps;
      reach = reach < 0 ? -reach : reach;
      if (reach > steps)
         steps = reach;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         walk = $urandom_range(0, steps);
      else if (pick < 20)
         walk = steps + $urandom_range(1, 3);
      else
         walk = steps;
      advance_line(walk);
      useful_items += 1 + (walk < steps ? walk : steps);
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      steady_sender = 1'b0;
      steady_receiver = 1'b0;
      useful_items = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle advances, single points, saturation, several octants, restart mid-line.
      advance_line(1);
      start_line(0, 0, 0, 0, 16'h0000);
      start_line(1023, 511, 1023, 511, 16'hFFFF);
      advance_line(1);
      start_line(3, 1, 1, 5, 16'hA5A5);
      advance_line(4);
      start_line(10, 10, 6, 8, 16'h5A5A);
      advance_line(4);
      start_line(0, 0, 639, 479, 16'hF800);
      advance_line(1);
      start_line(639, 0, 637, 0, 16'h07E0);
      advance_line(3);
      start_line(5, 0, 5, 3, 16'h001F);
      advance_line(3);
      wait_for_drain();

      // Random lines in phases, some with one side or both never idling.
      while (useful_items < TARGET_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            steady_sender = ($urandom_range(0, 2) == 0);
            steady_receiver = ($urandom_range(0, 2) == 0);
         end
         random_line();
         if ($urandom_range(0, 39) == 0)
            wait_for_drain();
      end
      wait_for_drain();

      if (board.owed_pixels.size() != 0)
         board.report_mismatch($sformatf("%0d pixels never arrived", board.owed_pixels.size()));
      $display("Covered %0d lines, %0d pixels checked, %0d advances with no line active.",
               board.lines_started, board.pixels_checked, board.idle_advances);
      if (board.errors == 0)
         $display("tb_line_pixel_generator: done, clean");
      else
         $display("tb_line_pixel_generator: done, errors");
      $finish;
   end

endmodule
